// File: hdl/hss_pkg.sv
// Shared types and constants for the 3D heat stencil step unit.
package hss_pkg;

  localparam int VW  = 24;          // Q10.14 temperature width
  localparam int SW  = 28;          // stencil sum width
  localparam int KW  = 15;          // coefficient width with sign room
  localparam int PW  = SW + KW;     // product width
  localparam int COEF = 10922;      // 0.16666 in Q0.16
  localparam int ROUND_BIT = 16;

  localparam logic [1:0] MODE_WR_CELL = 2'd0;
  localparam logic [1:0] MODE_WR_HALO = 2'd1;
  localparam logic [1:0] MODE_STEP    = 2'd2;
  localparam logic [1:0] MODE_RD_CELL = 2'd3;

  localparam logic [2:0] REG_SIZE_X   = 3'd0;
  localparam logic [2:0] REG_SIZE_Y   = 3'd1;
  localparam logic [2:0] REG_SIZE_Z   = 3'd2;
  localparam logic [2:0] REG_SRC_X    = 3'd3;
  localparam logic [2:0] REG_SRC_Y    = 3'd4;
  localparam logic [2:0] REG_SRC_Z    = 3'd5;
  localparam logic [2:0] REG_SRC_EN   = 3'd6;

  localparam logic [2:0] PH_CENTRE = 3'd0;
  localparam logic [2:0] PH_LEFT   = 3'd1;
  localparam logic [2:0] PH_RIGHT  = 3'd2;
  localparam logic [2:0] PH_UP     = 3'd3;
  localparam logic [2:0] PH_DOWN   = 3'd4;
  localparam logic [2:0] PH_FRONT  = 3'd5;
  localparam logic [2:0] PH_BACK   = 3'd6;
  localparam logic [2:0] PH_LAST   = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CELL,
    S_MUL,
    S_WRITE
  } state_t;

  typedef enum logic [1:0] {
    SRC_GRID,
    SRC_HALO,
    SRC_SELF
  } src_t;

endpackage

// File: hdl/hss_relax.sv
// Relaxation arithmetic: coefficient product, rounding and saturation.
module hss_relax (
  input  logic                       clk,
  input  logic                       load,
  input  logic signed [hss_pkg::SW-1:0] sum,
  input  logic signed [hss_pkg::VW-1:0] tc,
  output logic signed [hss_pkg::VW-1:0] result
);
  import hss_pkg::*;

  logic signed [PW-1:0]   prod;
  logic signed [VW-1:0]   tc_r;
  logic signed [PW-1:0]   rnd;
  logic signed [PW-17:0]  q;
  logic signed [PW-15:0]  r;

  // Register the product so the rounding add sits in the next cycle
  always_ff @(posedge clk) begin
    if (load) begin
      prod <= PW'(sum) * PW'($signed({1'b0, KW'(COEF)}));
      tc_r <= tc;
    end
  end

  // Round half up, shift, add and saturate
  always_comb begin
    rnd = prod + PW'(1 <<< (ROUND_BIT - 1));
    q   = rnd[PW-1:ROUND_BIT];
    r   = (PW-14)'(tc_r) + (PW-14)'(q);
    if (r > (PW-14)'((1 <<< (VW-1)) - 1)) begin
      result = VW'((1 <<< (VW-1)) - 1);
    end else if (r < -(PW-14)'(1 <<< (VW-1))) begin
      result = VW'(-(1 <<< (VW-1)));
    end else begin
      result = r[VW-1:0];
    end
  end

endmodule

// File: hdl/heat_stencil_3d_step_unit.sv
// Top level of the 3D Jacobi heat stencil step unit.
//  channel | direction | signals
//  in      | input     | in_valid in_ready mode pos_x pos_y pos_z face value_in
//  out     | output    | out_valid out_ready read_value status
//  cfg     | input     | cfg_we cfg_index cfg_data
// A cell or halo write registers its answer on acceptance; a cell read answers from S_READ.
// A step visits each cell in use in turn: up to seven one-port reads of the
// grid or halo memory in turn, one multiply state and one write-back state.
// Reset clears control state only; grid and halo memories hold no reset.
// No new transaction is taken while a result waits on out_ready.
module heat_stencil_3d_step_unit #(
  parameter int MAX_X = 16,
  parameter int MAX_Y = 16,
  parameter int MAX_Z = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           mode,
  input  logic [3:0]           pos_x,
  input  logic [3:0]           pos_y,
  input  logic [3:0]           pos_z,
  input  logic [1:0]           face,
  input  logic signed [hss_pkg::VW-1:0] value_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [hss_pkg::VW-1:0] read_value,
  output logic                 status,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [4:0]           cfg_data
);
  import hss_pkg::*;

  localparam int XY    = MAX_X * MAX_Y;
  localparam int CELLS = XY * MAX_Z;
  localparam int YFACE = MAX_X * MAX_Z;
  localparam int ZFACE = MAX_X * MAX_Y;
  localparam int HD    = 2 * YFACE + 2 * ZFACE;
  localparam int GW    = $clog2(2 * CELLS);
  localparam int HW    = $clog2(HD);
  localparam int XW    = $clog2(MAX_X);
  localparam int YW    = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int ZW    = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;

  // configuration
  logic [4:0] size_x, size_y, size_z;
  logic [3:0] src_x, src_y, src_z;
  logic       source_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= 5'd10; size_y <= 5'd10; size_z <= 5'd10;
      src_x <= 4'd2; src_y <= 4'd2; src_z <= 4'd2;
      source_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_X: size_x <= cfg_data;
        REG_SIZE_Y: size_y <= cfg_data;
        REG_SIZE_Z: size_z <= cfg_data;
        REG_SRC_X:  src_x <= cfg_data[3:0];
        REG_SRC_Y:  src_y <= cfg_data[3:0];
        REG_SRC_Z:  src_z <= cfg_data[3:0];
        REG_SRC_EN: source_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sizes in use
  logic [4:0] sx, sy, sz;
  assign sx = (32'(size_x) < MAX_X) ? size_x : 5'(MAX_X);
  assign sy = (32'(size_y) < MAX_Y) ? size_y : 5'(MAX_Y);
  assign sz = (32'(size_z) < MAX_Z) ? size_z : 5'(MAX_Z);

  // memories
  logic signed [VW-1:0] grid_mem [2*CELLS];
  logic signed [VW-1:0] halo_mem [HD];
  logic signed [VW-1:0] grid_q, halo_q, grid_wdata;
  logic [GW-1:0] grid_raddr, grid_waddr;
  logic [HW-1:0] halo_raddr, halo_waddr;
  logic grid_re, grid_we, halo_re, halo_we;

  always_ff @(posedge clk) begin
    if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
    if (grid_re) grid_q <= grid_mem[grid_raddr];
  end

  always_ff @(posedge clk) begin
    if (halo_we) halo_mem[halo_waddr] <= value_in;
    if (halo_re) halo_q <= halo_mem[halo_raddr];
  end

  // control registers
  state_t state, state_next;
  logic [2:0] phase;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [ZW-1:0] cz;
  logic current_is_b;
  src_t src_sel;
  logic signed [VW-1:0] tc;
  logic signed [SW-1:0] sum;
  logic signed [VW-1:0] relax_out;

  logic in_accept;
  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign in_accept = in_valid && in_ready;

  // request decode
  logic in_cell, in_yface, in_zface, zero_size;
  assign in_cell   = (5'(pos_x) < sx) && (5'(pos_y) < sy) && (5'(pos_z) < sz);
  assign in_yface  = (5'(pos_x) < sx) && (5'(pos_z) < sz);
  assign in_zface  = (5'(pos_x) < sx) && (5'(pos_y) < sy);
  assign zero_size = (sx == 5'd0) || (sy == 5'd0) || (sz == 5'd0);

  logic [31:0] in_idx, cur_off, nxt_off, ci, hy_idx, hz_idx, h_in;
  assign cur_off = current_is_b ? 32'(CELLS) : 32'd0;
  assign nxt_off = current_is_b ? 32'd0 : 32'(CELLS);
  assign in_idx  = 32'(pos_x) + MAX_X * (32'(pos_y) + MAX_Y * 32'(pos_z));
  assign h_in    = face[1]
    ? 32'(2 * YFACE) + (face[0] ? 32'(ZFACE) : 32'd0) + 32'(pos_y) * MAX_X + 32'(pos_x)
    : (face[0] ? 32'(YFACE) : 32'd0) + 32'(pos_z) * MAX_X + 32'(pos_x);
  assign ci      = 32'(cx) + MAX_X * (32'(cy) + MAX_Y * 32'(cz));
  assign hy_idx  = 32'(cz) * MAX_X + 32'(cx);
  assign hz_idx  = 32'(2 * YFACE) + 32'(cy) * MAX_X + 32'(cx);

  logic x_last, y_last, z_last, src_hit;
  assign x_last  = (32'(cx) == 32'(sx) - 1);
  assign y_last  = (32'(cy) == 32'(sy) - 1);
  assign z_last  = (32'(cz) == 32'(sz) - 1);
  assign src_hit = source_enable && (32'(cx) == 32'(src_x))
                && (32'(cy) == 32'(src_y)) && (32'(cz) == 32'(src_z));

  // neighbour fetch for the current phase
  src_t ph_src;
  logic [31:0] ph_gaddr, ph_haddr;
  always_comb begin
    ph_src   = SRC_GRID;
    ph_gaddr = ci;
    ph_haddr = hy_idx;
    case (phase)
      PH_CENTRE: ph_src = SRC_GRID;
      PH_LEFT: begin
        if (cx != '0) ph_gaddr = ci - 1;
        else ph_src = SRC_SELF;
      end
      PH_RIGHT: begin
        if (!x_last) ph_gaddr = ci + 1;
        else ph_src = SRC_SELF;
      end
      PH_UP: begin
        if (cy != '0) ph_gaddr = ci - MAX_X;
        else ph_src = SRC_HALO;
      end
      PH_DOWN: begin
        ph_haddr = hy_idx + YFACE;
        if (!y_last) ph_gaddr = ci + MAX_X;
        else ph_src = SRC_HALO;
      end
      PH_FRONT: begin
        ph_haddr = hz_idx;
        if (cz != '0) ph_gaddr = ci - XY;
        else ph_src = SRC_HALO;
      end
      PH_BACK: begin
        ph_haddr = hz_idx + ZFACE;
        if (!z_last) ph_gaddr = ci + XY;
        else ph_src = SRC_HALO;
      end
      default: ph_src = SRC_SELF;
    endcase
  end

  // next state and memory strobes
  always_comb begin
    state_next = state;
    grid_re    = 1'b0;
    grid_we    = 1'b0;
    halo_re    = 1'b0;
    halo_we    = 1'b0;
    grid_raddr = GW'(cur_off + ph_gaddr);
    grid_waddr = GW'(nxt_off + ci);
    grid_wdata = relax_out;
    halo_raddr = HW'(ph_haddr);
    halo_waddr = HW'(h_in);
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          grid_raddr = GW'(cur_off + in_idx);
          grid_waddr = GW'(cur_off + in_idx);
          grid_wdata = value_in;
          case (mode)
            MODE_WR_CELL: grid_we = in_cell;
            MODE_WR_HALO: halo_we = face[1] ? in_zface : in_yface;
            MODE_STEP:    if (!zero_size) state_next = S_CELL;
            MODE_RD_CELL: begin
              grid_re = in_cell;
              if (in_cell) state_next = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: state_next = S_IDLE;
      S_CELL: begin
        if (phase != PH_LAST) begin
          grid_re = (ph_src == SRC_GRID);
          halo_re = (ph_src == SRC_HALO);
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: state_next = S_WRITE;
      S_WRITE: begin
        grid_we    = 1'b1;
        state_next = (x_last && y_last && z_last) ? S_IDLE : S_CELL;
      end
      default: state_next = S_IDLE;
    endcase
  end

  logic sweep_done;
  assign sweep_done = (state == S_WRITE) && x_last && y_last && z_last;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // phase, cell counters and buffer select
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_CENTRE;
      cx <= '0; cy <= '0; cz <= '0;
      current_is_b <= 1'b0;
    end else begin
      if (state == S_CELL) phase <= phase + 3'd1;
      else phase <= PH_CENTRE;
      if (state == S_WRITE) begin
        if (!x_last) cx <= cx + 1'b1;
        else begin
          cx <= '0;
          if (!y_last) cy <= cy + 1'b1;
          else begin
            cy <= '0;
            cz <= z_last ? '0 : cz + 1'b1;
          end
        end
      end
      if (sweep_done || (in_accept && mode == MODE_STEP && zero_size)) begin
        current_is_b <= !current_is_b;
      end
    end
  end

  // accumulate the stencil sum as reads return
  logic signed [VW-1:0] nb;
  always_comb begin
    case (src_sel)
      SRC_GRID: nb = grid_q;
      SRC_HALO: nb = halo_q;
      default:  nb = tc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_CELL) begin
      src_sel <= ph_src;
      if (phase == PH_LEFT) begin
        tc  <= grid_q;
        sum <= -((SW'(grid_q) <<< 2) + (SW'(grid_q) <<< 1));
      end else if (phase != PH_CENTRE) begin
        sum <= sum + SW'(nb);
      end
    end
  end

  hss_relax u_relax (
    .clk    (clk),
    .load   (state == S_MUL),
    .sum    (src_hit ? SW'(0) : sum),
    .tc     (tc),
    .result (relax_out)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (in_accept) begin
        case (mode)
          MODE_WR_CELL: begin
            out_valid <= 1'b1; status <= !in_cell; read_value <= '0;
          end
          MODE_WR_HALO: begin
            out_valid  <= 1'b1;
            status     <= face[1] ? !in_zface : !in_yface;
            read_value <= '0;
          end
          MODE_STEP: begin
            out_valid <= zero_size; status <= 1'b0; read_value <= '0;
          end
          MODE_RD_CELL: begin
            out_valid <= !in_cell; status <= !in_cell; read_value <= '0;
          end
          default: ;
        endcase
      end
      if (state == S_READ) begin
        out_valid <= 1'b1; status <= 1'b0; read_value <= grid_q;
      end
      if (sweep_done) begin
        out_valid <= 1'b1; status <= 1'b0; read_value <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_no_accept : assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("transaction taken while busy");
  a_grid_write_src : assert property (@(posedge clk) disable iff (rst)
    grid_we |-> ((state == S_WRITE) || (in_accept && mode == MODE_WR_CELL)))
    else $error("unexpected grid write");
  a_swap_on_done : assert property (@(posedge clk) disable iff (rst)
    sweep_done |=> (current_is_b != $past(current_is_b)))
    else $error("buffers not swapped after sweep");
  a_done_result : assert property (@(posedge clk) disable iff (rst)
    sweep_done |=> out_valid)
    else $error("sweep ended without result");
`endif

endmodule

// File: test/heat_stencil_3d_step_unit_checker.sv
// Channel monitor, stencil predictor and result comparison for the heat stencil step unit.
module heat_stencil_3d_step_unit_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [1:0]           mode,
  input  logic [3:0]           pos_x,
  input  logic [3:0]           pos_y,
  input  logic [3:0]           pos_z,
  input  logic [1:0]           face,
  input  logic signed [hss_pkg::VW-1:0] value_in,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [hss_pkg::VW-1:0] read_value,
  input  logic                 status,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [4:0]           cfg_data,
  output int                   errors,
  output int                   pending
);
  import hss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NX = 16;
  localparam int NY = 16;
  localparam int NZ = 16;
  localparam int VMAX = 8388607;
  localparam int VMIN = -8388608;

  // shadow state of the block
  int          temp_grid [2][NX*NY*NZ];
  int          halo_y [2*NX*NZ];
  int          halo_z [2*NX*NY];
  bit          cur_sel;
  int unsigned dim_x, dim_y, dim_z, hot_x, hot_y, hot_z;
  bit          hot_en;

  // expected results, oldest first
  logic [VW-1:0] exp_value [$];
  bit            exp_status [$];

  assign pending = exp_value.size();

  initial errors = 0;

  function automatic int unsigned clip(int unsigned s, int unsigned m);
    return s < m ? s : m;
  endfunction

  function automatic int cell_at(int unsigned x, int unsigned y, int unsigned z);
    return x + NX * (y + NY * z);
  endfunction

  // one Jacobi sweep from the current buffer into the other, then swap
  function automatic void jacobi_sweep();
    int unsigned ux, uy, uz;
    int i, tc;
    longint sum, prod, upd;
    ux = clip(dim_x, NX);
    uy = clip(dim_y, NY);
    uz = clip(dim_z, NZ);
    for (int unsigned z = 0; z < uz; z++)
      for (int unsigned y = 0; y < uy; y++)
        for (int unsigned x = 0; x < ux; x++) begin
          i = cell_at(x, y, z);
          tc = temp_grid[cur_sel][i];
          if (hot_en && x == hot_x && y == hot_y && z == hot_z) begin
            temp_grid[!cur_sel][i] = tc;
            continue;
          end
          sum = -6 * longint'(tc);
          sum += (x != 0) ? temp_grid[cur_sel][i-1] : tc;
          sum += (x != ux - 1) ? temp_grid[cur_sel][i+1] : tc;
          sum += (y != 0) ? temp_grid[cur_sel][i-NX] : halo_y[z*NX + x];
          sum += (y != uy - 1) ? temp_grid[cur_sel][i+NX] : halo_y[NX*NZ + z*NX + x];
          sum += (z != 0) ? temp_grid[cur_sel][i-NX*NY] : halo_z[y*NX + x];
          sum += (z != uz - 1) ? temp_grid[cur_sel][i+NX*NY]
                                : halo_z[NX*NY + y*NX + x];
          // round half up, then saturate
          prod = sum * COEF;
          upd = longint'(tc) + ((prod + 64'sd32768) >>> 16);
          if (upd > VMAX) upd = VMAX;
          if (upd < VMIN) upd = VMIN;
          temp_grid[!cur_sel][i] = int'(upd);
        end
    cur_sel = !cur_sel;
  endfunction

  function automatic void predict_transaction(logic [1:0] m, int unsigned x, int unsigned y,
                                              int unsigned z, int unsigned f, int v);
    int unsigned ux, uy, uz;
    bit in_grid;
    logic [VW-1:0] rv;
    bit st;
    ux = clip(dim_x, NX);
    uy = clip(dim_y, NY);
    uz = clip(dim_z, NZ);
    in_grid = x < ux && y < uy && z < uz;
    rv = '0;
    st = 0;
    case (m)
      MODE_WR_CELL: begin
        if (in_grid) temp_grid[cur_sel][cell_at(x, y, z)] = v;
        else st = 1;
      end
      MODE_WR_HALO: begin
        if (f < 2) begin
          if (x < ux && z < uz) halo_y[f*NX*NZ + z*NX + x] = v;
          else st = 1;
        end else begin
          if (x < ux && y < uy) halo_z[(f-2)*NX*NY + y*NX + x] = v;
          else st = 1;
        end
      end
      MODE_STEP: jacobi_sweep();
      default: begin
        if (in_grid) rv = temp_grid[cur_sel][cell_at(x, y, z)];
        else st = 1;
      end
    endcase
    exp_value.push_back(rv);
    exp_status.push_back(st);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_sel = 0;
      dim_x = 10; dim_y = 10; dim_z = 10;
      hot_x = 2; hot_y = 2; hot_z = 2;
      hot_en = 1;
      exp_value.delete();
      exp_status.delete();
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_SIZE_X: dim_x = cfg_data;
          REG_SIZE_Y: dim_y = cfg_data;
          REG_SIZE_Z: dim_z = cfg_data;
          REG_SRC_X:  hot_x = cfg_data[3:0];
          REG_SRC_Y:  hot_y = cfg_data[3:0];
          REG_SRC_Z:  hot_z = cfg_data[3:0];
          REG_SRC_EN: hot_en = cfg_data[0];
          default: ;
        endcase
      end
      // compare the result transaction with the oldest expectation
      if (out_valid && out_ready) begin
        if (exp_value.size() == 0) begin
          report_mismatch("unexpected result transaction", 1, 0);
        end else begin
          if (read_value !== exp_value[0])
            report_mismatch("read_value", $signed(read_value), $signed(exp_value[0]));
          if (status !== exp_status[0])
            report_mismatch("status", status, exp_status[0]);
          void'(exp_value.pop_front());
          void'(exp_status.pop_front());
        end
      end
      // predict for an accepted input transaction
      if (in_valid && in_ready)
        predict_transaction(mode, pos_x, pos_y, pos_z, face, value_in);
    end
  end

endmodule

// File: test/heat_stencil_3d_step_unit_tb.sv
// Stimulus, clock, reset and verdict for the heat stencil step unit testbench.
module heat_stencil_3d_step_unit_tb;
  import hss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int NPHASE = 5;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 in_valid = 0;
  logic                 in_ready;
  logic [1:0]           mode = MODE_WR_CELL;
  logic [3:0]           pos_x = 0, pos_y = 0, pos_z = 0;
  logic [1:0]           face = 0;
  logic signed [VW-1:0] value_in = 0;
  logic                 out_valid;
  logic                 out_ready = 0;
  logic signed [VW-1:0] read_value;
  logic                 status;
  logic                 cfg_we = 0;
  logic [2:0]           cfg_index = REG_SIZE_X;
  logic [4:0]           cfg_data = 0;
  int                   errors, pending;
  bit                   calm = 0;
  int                   quiet_cycles = 0;

  // settings per phase: size x, y, z, source x, y, z, source enable, random items
  int phase_cfg [NPHASE][8] = '{
    '{ 2,  2,  2,  1,  1,  1, 1,  4},
    '{ 3,  2,  1,  1,  0,  0, 0,  6},
    '{ 1,  1,  1,  3,  0,  0, 1,  6},
    '{ 0,  2,  1,  0,  0,  0, 1,  6},
    '{ 1,  1, 31,  0,  0, 15, 1,  6}
  };
  int ux, uy, uz;

  heat_stencil_3d_step_unit uut (.*);

  heat_stencil_3d_step_unit_checker chk (.*);

  always #5 clk = ~clk;

  // receiver: stall at random unless in a calm stretch
  always @(posedge clk)
    out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 34);

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(logic [1:0] m, int x, int y, int z, int f, int v);
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    mode <= m;
    pos_x <= 4'(x);
    pos_y <= 4'(y);
    pos_z <= 4'(z);
    face <= 2'(f);
    value_in <= VW'(v);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic int rand_temp();
    return $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
  endfunction

  // coordinate mostly inside the grid, sometimes anywhere
  function automatic int pick(int use_n);
    if (use_n == 0 || $urandom_range(0, 99) < 15) return $urandom_range(0, 15);
    return $urandom_range(0, use_n - 1);
  endfunction

  // write every cell and halo entry that a sweep may read
  task automatic fill_grid();
    for (int z = 0; z < uz; z++)
      for (int y = 0; y < uy; y++)
        for (int x = 0; x < ux; x++)
          send(MODE_WR_CELL, x, y, z, $urandom_range(0, 3), rand_temp());
    for (int f = 0; f < 2; f++)
      for (int z = 0; z < uz; z++)
        for (int x = 0; x < ux; x++)
          send(MODE_WR_HALO, x, $urandom_range(0, 15), z, f, rand_temp());
    for (int f = 2; f < 4; f++)
      for (int y = 0; y < uy; y++)
        for (int x = 0; x < ux; x++)
          send(MODE_WR_HALO, x, y, $urandom_range(0, 15), f, rand_temp());
  endtask

  // edge values, outside coordinates, ignored halo coordinates and the source cell
  task automatic directed_items();
    send(MODE_WR_CELL, 0, 0, 0, 0, -8388608);
    send(MODE_WR_CELL, 1, 1, 0, 3, 8388607);
    send(MODE_RD_CELL, 0, 0, 0, 0, 0);
    send(MODE_WR_CELL, 2, 0, 0, 0, 5);
    send(MODE_WR_CELL, 15, 15, 15, 0, 5);
    send(MODE_RD_CELL, 0, 0, 2, 0, 0);
    send(MODE_WR_HALO, 1, 15, 0, 0, 8388607);
    send(MODE_WR_HALO, 0, 0, 2, 1, 1);
    send(MODE_WR_HALO, 1, 1, 15, 2, -8388608);
    send(MODE_WR_HALO, 0, 2, 0, 3, 1);
    send(MODE_STEP, 0, 0, 0, 0, 0);
    send(MODE_RD_CELL, 1, 1, 1, 0, 0);
    send(MODE_RD_CELL, 0, 0, 0, 0, 0);
    send(MODE_STEP, 15, 15, 15, 3, -1);
    send(MODE_RD_CELL, 1, 0, 1, 0, 0);
  endtask

  task automatic random_items(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 10)
        send(MODE_STEP, $urandom_range(0, 15), $urandom_range(0, 15),
             $urandom_range(0, 15), $urandom_range(0, 3), rand_temp());
      else if (r < 40)
        send(MODE_WR_CELL, pick(ux), pick(uy), pick(uz), $urandom_range(0, 3), rand_temp());
      else if (r < 55)
        send(MODE_WR_HALO, pick(ux), pick(uy), pick(uz), $urandom_range(0, 3), rand_temp());
      else
        send(MODE_RD_CELL, pick(ux), pick(uy), pick(uz), $urandom_range(0, 3), rand_temp());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int p = 0; p < NPHASE; p++) begin
      drain();
      calm = (p == 4);
      // program every register while the block is idle
      for (int r = 0; r < 7; r++) begin
        cfg_we <= 1;
        cfg_index <= 3'(r);
        cfg_data <= 5'(phase_cfg[p][r]);
        @(posedge clk);
      end
      cfg_we <= 0;
      ux = phase_cfg[p][0] < 16 ? phase_cfg[p][0] : 16;
      uy = phase_cfg[p][1] < 16 ? phase_cfg[p][1] : 16;
      uz = phase_cfg[p][2] < 16 ? phase_cfg[p][2] : 16;
      fill_grid();
      if (p == 0) directed_items();
      random_items(phase_cfg[p][7]);
    end
    drain();
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: heat_stencil_3d_step_unit.f
hdl/hss_pkg.sv
hdl/hss_relax.sv
hdl/heat_stencil_3d_step_unit.sv
test/heat_stencil_3d_step_unit_checker.sv
test/heat_stencil_3d_step_unit_tb.sv
